[rtl/tvg_pkg.sv]
// shared types, constants and rounding and saturation helpers for the torus vertex generator
package tvg_pkg;

  localparam int IDX_W        = 11;
  localparam int CNT_W        = 11;
  localparam int RAD_W        = 16;
  localparam int CFG_W        = 16;
  localparam int POS_W        = 18;
  localparam int NRM_W        = 16;
  localparam int TEX_W        = 17;
  localparam int TEX_FRAC     = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int TURN_W       = 32;
  localparam int QUO_W        = TEX_FRAC + 1;
  localparam int NUM_W        = IDX_W + TEX_FRAC;
  localparam int DIV_PER      = 3;
  localparam int DIV_STAGES   = (QUO_W + DIV_PER - 1) / DIV_PER;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int VTX_LAT      = 4;
  localparam int XY_W         = 34;
  localparam int MIN_SEG      = 3;
  localparam int MAX_SEG      = 1024;

  localparam logic [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
  localparam longint POS_MAX  = 131071;
  localparam longint POS_MIN  = -131072;
  localparam longint UNIT_Q14 = 16384;

  typedef enum logic [1:0] {
    REG_TUBE_RADIUS  = 2'd0,
    REG_SWEEP_RADIUS = 2'd1,
    REG_TUBE_SEGS    = 2'd2,
    REG_RING_SEGS    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // round half away from zero, then shift right
  function automatic logic signed [63:0] round_sh(input logic signed [63:0] v,
                                                  input int unsigned s);
    logic signed [63:0] mag;
    logic signed [63:0] res;
    mag = v[63] ? -v : v;
    res = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return v[63] ? -res : res;
  endfunction

  function automatic logic signed [63:0] clamp_s(input logic signed [63:0] v,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
    logic signed [63:0] res;
    res = (v < lo) ? lo : ((v > hi) ? hi : v);
    return res;
  endfunction

endpackage

[rtl/tvg_div.sv]
// pipelined restoring divider: (idx * 2^16 + cnt / 2) / cnt, up to three quotient bits a stage
module tvg_div (
  input  logic                       clk_i,
  input  logic                       ce_i,
  input  logic [tvg_pkg::IDX_W-1:0]  idx_i,
  input  logic [tvg_pkg::CNT_W-1:0]  cnt_i,
  output logic [tvg_pkg::QUO_W-1:0]  quo_o
);
  import tvg_pkg::*;

  logic [NUM_W-1:0] num0;
  logic [CNT_W-1:0] rem_in [DIV_STAGES];
  logic [QUO_W-1:0] low_in [DIV_STAGES];
  logic [CNT_W-1:0] den_in [DIV_STAGES];
  logic [CNT_W-1:0] rem_q  [DIV_STAGES];
  logic [QUO_W-1:0] low_q  [DIV_STAGES];
  logic [CNT_W-1:0] den_q  [DIV_STAGES];

  assign num0 = {idx_i, TEX_FRAC'(0)} + NUM_W'(cnt_i >> 1);

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
    logic [CNT_W-1:0] rem_s;
    logic [QUO_W-1:0] low_s;
    logic [CNT_W:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in[k] = CNT_W'(num0[NUM_W-1:QUO_W]);
      assign low_in[k] = num0[QUO_W-1:0];
      assign den_in[k] = cnt_i;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign low_in[k] = low_q[k-1];
      assign den_in[k] = den_q[k-1];
    end

    always_comb begin
      rem_s = rem_in[k];
      low_s = low_in[k];
      trial = '0;
      for (int t = 0; t < DIV_PER; t++) begin
        if (k * DIV_PER + t < QUO_W) begin
          trial = {rem_s, low_s[QUO_W-1]};
          if (trial >= {1'b0, den_in[k]}) begin
            rem_s = CNT_W'(trial - {1'b0, den_in[k]});
            low_s = {low_s[QUO_W-2:0], 1'b1};
          end else begin
            rem_s = trial[CNT_W-1:0];
            low_s = {low_s[QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[k] <= rem_s;
        low_q[k] <= low_s;
        den_q[k] <= den_in[k];
      end
    end
  end

  assign quo_o = low_q[DIV_STAGES-1];

endmodule

[rtl/tvg_cordic.sv]
// pipelined rotation cordic: angle in turns to q1.14 cosine and sine
module tvg_cordic (
  input  logic                             clk_i,
  input  logic                             ce_i,
  input  logic [tvg_pkg::ANGLE_BITS-1:0]   angle_i,
  output logic signed [tvg_pkg::NRM_W-1:0] cos_o,
  output logic signed [tvg_pkg::NRM_W-1:0] sin_o
);
  import tvg_pkg::*;

  logic [TURN_W-1:0]        turn;
  logic [TURN_W-1:0]        turn_off;
  logic [1:0]               quad;
  logic [TURN_W-1:0]        red;
  logic signed [XY_W-1:0]   x_q [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]   y_q [CORDIC_STEPS+1];
  logic signed [TURN_W-1:0] z_q [CORDIC_STEPS+1];
  quad_e                    quad_q [CORDIC_STEPS+1];
  logic signed [63:0]       cc64;
  logic signed [63:0]       ss64;
  logic signed [NRM_W-1:0]  cc;
  logic signed [NRM_W-1:0]  ss;
  logic signed [NRM_W-1:0]  c_d, s_d, c_q, s_q;

  // fold into +-1/8 turn and remember the quadrant
  assign turn     = {angle_i, (TURN_W-ANGLE_BITS)'(0)};
  assign turn_off = turn + 32'h2000_0000;
  assign quad     = turn_off[TURN_W-1:TURN_W-2];
  assign red      = turn - {quad, (TURN_W-2)'(0)};

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= $signed(red);
      quad_q[0] <= quad_e'(quad);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XY_W-1:0] dx, dy;
    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        if (!z_q[i][TURN_W-1]) begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - $signed(ATAN_TURNS[i]);
        end else begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + $signed(ATAN_TURNS[i]);
        end
        quad_q[i+1] <= quad_q[i];
      end
    end
  end

  always_comb begin
    cc64 = clamp_s(round_sh(64'(x_q[CORDIC_STEPS]), 16), -64'(UNIT_Q14), 64'(UNIT_Q14));
    ss64 = clamp_s(round_sh(64'(y_q[CORDIC_STEPS]), 16), -64'(UNIT_Q14), 64'(UNIT_Q14));
    cc   = cc64[NRM_W-1:0];
    ss   = ss64[NRM_W-1:0];
    unique case (quad_q[CORDIC_STEPS])
      QUAD_0: begin c_d = cc;  s_d = ss;  end
      QUAD_1: begin c_d = -ss; s_d = cc;  end
      QUAD_2: begin c_d = -cc; s_d = -ss; end
      QUAD_3: begin c_d = ss;  s_d = -cc; end
      default: begin c_d = cc; s_d = ss;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      c_q <= c_d;
      s_q <= s_d;
    end
  end

  assign cos_o = c_q;
  assign sin_o = s_q;

endmodule

[rtl/tvg_vertex.sv]
// position and normal products, rounding and saturation, invalid-vertex zeroing
module tvg_vertex (
  input  logic                             clk_i,
  input  logic                             ce_i,
  input  logic [tvg_pkg::RAD_W-1:0]        tube_radius_i,
  input  logic [tvg_pkg::RAD_W-1:0]        sweep_radius_i,
  input  logic signed [tvg_pkg::NRM_W-1:0] ca_i,
  input  logic signed [tvg_pkg::NRM_W-1:0] sa_i,
  input  logic signed [tvg_pkg::NRM_W-1:0] cb_i,
  input  logic signed [tvg_pkg::NRM_W-1:0] sb_i,
  input  logic                             ok_i,
  input  logic [tvg_pkg::TEX_W-1:0]        tex_u_i,
  input  logic [tvg_pkg::TEX_W-1:0]        tex_v_i,
  output logic signed [tvg_pkg::POS_W-1:0] pos_x_o,
  output logic signed [tvg_pkg::POS_W-1:0] pos_y_o,
  output logic signed [tvg_pkg::POS_W-1:0] pos_z_o,
  output logic signed [tvg_pkg::NRM_W-1:0] normal_x_o,
  output logic signed [tvg_pkg::NRM_W-1:0] normal_y_o,
  output logic signed [tvg_pkg::NRM_W-1:0] normal_z_o,
  output logic [tvg_pkg::TEX_W-1:0]        tex_u_o,
  output logic [tvg_pkg::TEX_W-1:0]        tex_v_o,
  output logic                             vertex_valid_o
);
  import tvg_pkg::*;

  localparam int PR_W  = RAD_W + 1 + NRM_W;
  localparam int NN_W  = 2 * NRM_W;
  localparam int RHO_W = PR_W + 2;
  localparam int M_W   = RHO_W + NRM_W;

  // stage 1
  logic signed [PR_W-1:0]  prc_q, prs_q;
  logic signed [NN_W-1:0]  nx1_q, nz1_q;
  logic signed [NRM_W-1:0] sa1_q, cb1_q, sb1_q;
  logic                    ok1_q;
  logic [TEX_W-1:0]        u1_q, v1_q;
  // stage 2
  logic signed [RHO_W-1:0] rho_q;
  logic signed [POS_W-1:0] py2_q;
  logic signed [NRM_W-1:0] nx2_q, ny2_q, nz2_q, cb2_q, sb2_q;
  logic                    ok2_q;
  logic [TEX_W-1:0]        u2_q, v2_q;
  // stage 3
  logic signed [M_W-1:0]   mx_q, mz_q;
  logic signed [POS_W-1:0] py3_q;
  logic signed [NRM_W-1:0] nx3_q, ny3_q, nz3_q;
  logic                    ok3_q;
  logic [TEX_W-1:0]        u3_q, v3_q;
  // stage 4
  logic signed [POS_W-1:0] px4_q, py4_q, pz4_q;
  logic signed [NRM_W-1:0] nx4_q, ny4_q, nz4_q;
  logic                    ok4_q;
  logic [TEX_W-1:0]        u4_q, v4_q;

  logic signed [63:0] py64, nx64, nz64, px64, pz64;
  logic signed [RHO_W-1:0] sweep_q14;

  assign sweep_q14 = RHO_W'($signed({1'b0, sweep_radius_i, 14'b0}));

  always_comb begin
    py64 = clamp_s(round_sh(64'(prs_q), 14), 64'(POS_MIN), 64'(POS_MAX));
    nx64 = clamp_s(round_sh(64'(nx1_q), 14), -64'(UNIT_Q14), 64'(UNIT_Q14));
    nz64 = clamp_s(round_sh(64'(nz1_q), 14), -64'(UNIT_Q14), 64'(UNIT_Q14));
    px64 = clamp_s(round_sh(64'(mx_q), 28), 64'(POS_MIN), 64'(POS_MAX));
    pz64 = clamp_s(round_sh(64'(mz_q), 28), 64'(POS_MIN), 64'(POS_MAX));
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      prc_q <= $signed({1'b0, tube_radius_i}) * ca_i;
      prs_q <= $signed({1'b0, tube_radius_i}) * sa_i;
      nx1_q <= ca_i * cb_i;
      nz1_q <= ca_i * sb_i;
      sa1_q <= sa_i;
      cb1_q <= cb_i;
      sb1_q <= sb_i;
      ok1_q <= ok_i;
      u1_q  <= tex_u_i;
      v1_q  <= tex_v_i;

      rho_q <= RHO_W'(prc_q) + sweep_q14;
      py2_q <= py64[POS_W-1:0];
      nx2_q <= nx64[NRM_W-1:0];
      ny2_q <= sa1_q;
      nz2_q <= nz64[NRM_W-1:0];
      cb2_q <= cb1_q;
      sb2_q <= sb1_q;
      ok2_q <= ok1_q;
      u2_q  <= u1_q;
      v2_q  <= v1_q;

      mx_q  <= rho_q * cb2_q;
      mz_q  <= rho_q * sb2_q;
      py3_q <= py2_q;
      nx3_q <= nx2_q;
      ny3_q <= ny2_q;
      nz3_q <= nz2_q;
      ok3_q <= ok2_q;
      u3_q  <= u2_q;
      v3_q  <= v2_q;

      px4_q <= ok3_q ? px64[POS_W-1:0] : '0;
      py4_q <= ok3_q ? py3_q : '0;
      pz4_q <= ok3_q ? pz64[POS_W-1:0] : '0;
      nx4_q <= ok3_q ? nx3_q : '0;
      ny4_q <= ok3_q ? ny3_q : '0;
      nz4_q <= ok3_q ? nz3_q : '0;
      u4_q  <= ok3_q ? u3_q : '0;
      v4_q  <= ok3_q ? v3_q : '0;
      ok4_q <= ok3_q;
    end
  end

  assign pos_x_o        = px4_q;
  assign pos_y_o        = py4_q;
  assign pos_z_o        = pz4_q;
  assign normal_x_o     = nx4_q;
  assign normal_y_o     = ny4_q;
  assign normal_z_o     = nz4_q;
  assign tex_u_o        = u4_q;
  assign tex_v_o        = v4_q;
  assign vertex_valid_o = ok4_q;

endmodule

[rtl/torus_vertex_generator_core.sv]
// torus vertex generator top level: config registers, pipeline control, dividers, cordics
// One vertex per clock when the output is taken every cycle; from input beat to output beat
// a vertex passes six divider stages for the grid fractions, a 32-stage CORDIC (angle
// fold, thirty rotations, rounding) for the sines and cosines, and four product stages. The
// whole pipeline advances together and holds while an output beat waits, so the input is
// ready whenever the output register is empty or being taken.
module torus_vertex_generator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [tvg_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // ring_index, segment_index, pad
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v
  output logic [135:0]                m_axis_tdata,
  output logic                        m_axis_tuser   // vertex_valid
);
  import tvg_pkg::*;

  localparam int LAT    = DIV_STAGES + CORDIC_LAT + VTX_LAT;
  localparam int OK_LEN = DIV_STAGES + CORDIC_LAT;

  logic [RAD_W-1:0] tube_radius_q, sweep_radius_q;
  logic [CNT_W-1:0] tube_segs_q, ring_segs_q;
  logic             ce;
  logic [IDX_W-1:0] ring_idx, seg_idx;
  logic             ok_in;
  logic [LAT-1:0]   vld_q;
  logic [OK_LEN-1:0] ok_q;
  logic [QUO_W-1:0] quo_u, quo_v;
  logic [TEX_W-1:0] tu_q [CORDIC_LAT];
  logic [TEX_W-1:0] tv_q [CORDIC_LAT];
  logic signed [NRM_W-1:0] ca, sa, cb, sb;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic signed [NRM_W-1:0] nrm_x, nrm_y, nrm_z;
  logic [TEX_W-1:0] tex_u, tex_v;
  logic             vtx_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tube_radius_q  <= '0;
      sweep_radius_q <= '0;
      tube_segs_q    <= '0;
      ring_segs_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TUBE_RADIUS:  tube_radius_q  <= cfg_data_i;
        REG_SWEEP_RADIUS: sweep_radius_q <= cfg_data_i;
        REG_TUBE_SEGS:    tube_segs_q    <= cfg_data_i[CNT_W-1:0];
        REG_RING_SEGS:    ring_segs_q    <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;
  assign ring_idx      = s_axis_tdata[IDX_W-1:0];
  assign seg_idx       = s_axis_tdata[2*IDX_W-1:IDX_W];

  assign ok_in = (tube_segs_q >= CNT_W'(MIN_SEG)) && (ring_segs_q >= CNT_W'(MIN_SEG)) &&
                 (tube_segs_q <= CNT_W'(MAX_SEG)) && (ring_segs_q <= CNT_W'(MAX_SEG)) &&
                 (seg_idx <= tube_segs_q) && (ring_idx <= ring_segs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      ok_q <= {ok_q[OK_LEN-2:0], ok_in};
    end
  end

  tvg_div u_div_ring (
    .clk_i (clk_i),
    .ce_i  (ce),
    .idx_i (ring_idx),
    .cnt_i (ring_segs_q),
    .quo_o (quo_u)
  );

  tvg_div u_div_seg (
    .clk_i (clk_i),
    .ce_i  (ce),
    .idx_i (seg_idx),
    .cnt_i (tube_segs_q),
    .quo_o (quo_v)
  );

  // texture fractions wait for the cordics
  for (genvar i = 0; i < CORDIC_LAT; i++) begin : g_tex
    always_ff @(posedge clk_i) begin
      if (ce) begin
        tu_q[i] <= (i == 0) ? TEX_W'(quo_u) : tu_q[(i == 0) ? 0 : i-1];
        tv_q[i] <= (i == 0) ? TEX_W'(quo_v) : tv_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  tvg_cordic u_cordic_tube (
    .clk_i   (clk_i),
    .ce_i    (ce),
    .angle_i (quo_v[ANGLE_BITS-1:0]),
    .cos_o   (ca),
    .sin_o   (sa)
  );

  tvg_cordic u_cordic_sweep (
    .clk_i   (clk_i),
    .ce_i    (ce),
    .angle_i (quo_u[ANGLE_BITS-1:0]),
    .cos_o   (cb),
    .sin_o   (sb)
  );

  tvg_vertex u_vertex (
    .clk_i          (clk_i),
    .ce_i           (ce),
    .tube_radius_i  (tube_radius_q),
    .sweep_radius_i (sweep_radius_q),
    .ca_i           (ca),
    .sa_i           (sa),
    .cb_i           (cb),
    .sb_i           (sb),
    .ok_i           (ok_q[OK_LEN-1]),
    .tex_u_i        (tu_q[CORDIC_LAT-1]),
    .tex_v_i        (tv_q[CORDIC_LAT-1]),
    .pos_x_o        (pos_x),
    .pos_y_o        (pos_y),
    .pos_z_o        (pos_z),
    .normal_x_o     (nrm_x),
    .normal_y_o     (nrm_y),
    .normal_z_o     (nrm_z),
    .tex_u_o        (tex_u),
    .tex_v_o        (tex_v),
    .vertex_valid_o (vtx_ok)
  );

  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tdata  = {tex_v, tex_u, nrm_z, nrm_y, nrm_x, pos_z, pos_y, pos_x};
  assign m_axis_tuser  = vtx_ok;

  // an invalid vertex carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid vertex with nonzero fields");

  // a stalled pipeline keeps its occupancy
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ce |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  // normal x and z components stay within unit range
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(nrm_x) <= 16'sd16384) && ($signed(nrm_x) >= -16'sd16384) &&
                      ($signed(nrm_z) <= 16'sd16384) && ($signed(nrm_z) >= -16'sd16384))
    else $error("normal out of range");

endmodule
